>>> sv/dtp_pkg.sv
// Shared types and constants for the disparity reprojection pipeline.
package dtp_pkg;

	localparam int Q_WORD    = 32;
	localparam int Q_REG_W   = 64;
	localparam int NUM_QREGS = 8;
	localparam int NUM_COEF  = 16;
	localparam int CFG_ADDR_W = 4;
	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = 32;
	localparam int DISP_W    = 16;

	// Control that travels beside the data through every stage.
	typedef struct packed {
		logic valid;
		logic live;
		logic fault;
	} ctl_t;

endpackage

>>> sv/dtp_mac.sv
// Matrix-vector product: one stage of products, one stage of row sums.
module dtp_mac import dtp_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int ACC_W      = 51
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [COORD_BITS-1:0]        pixel_col,
	input  logic [COORD_BITS-1:0]        pixel_row,
	input  logic signed [DISP_W-1:0]     disparity_raw,
	input  logic signed [Q_WORD-1:0]     coef [NUM_COEF],
	output logic signed [ACC_W-1:0]      acc [4],
	output ctl_t                         ctl
);

	localparam int VW = COORD_BITS + 5;

	logic signed [VW-1:0] x16, y16;
	logic signed [ACC_W-1:0] prod_s1 [NUM_COEF];
	ctl_t ctl_s1, ctl_s2;
	logic signed [ACC_W-1:0] acc_s2 [4];

	assign x16 = $signed({1'b0, pixel_col, 4'b0000});
	assign y16 = $signed({1'b0, pixel_row, 4'b0000});

	// Sixteen products: twelve signed multiplies and four constant terms shifted left by four.
	for (genvar r = 0; r < 4; r++) begin : g_row
		logic signed [Q_WORD+VW-1:0]     px, py;
		logic signed [Q_WORD+DISP_W-1:0] pd;
		assign px = coef[r*4] * x16;
		assign py = coef[r*4+1] * y16;
		assign pd = coef[r*4+2] * disparity_raw;
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[r*4]   <= ACC_W'(px);
				prod_s1[r*4+1] <= ACC_W'(py);
				prod_s1[r*4+2] <= ACC_W'(pd);
				prod_s1[r*4+3] <= ACC_W'(coef[r*4+3]) <<< 4;
			end
		end
		// Row sums are exact.
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s2[r] <= prod_s1[r*4] + prod_s1[r*4+1] + prod_s1[r*4+2] + prod_s1[r*4+3];
			end
		end
	end

	// Valid and the positive-disparity flag follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.live  <= in_valid && (disparity_raw > 0);
			ctl_s1.fault <= 1'b0;
			ctl_s2       <= ctl_s1;
		end
	end

	assign acc = acc_s2;
	assign ctl = ctl_s2;

endmodule

>>> sv/dtp_div_lane.sv
// Pipelined restoring divider: one quotient bit per stage, with saturation.
module dtp_div_lane import dtp_pkg::*; #(
	parameter int ACC_W = 51
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	output logic [Q_WORD-1:0]       quot,
	output logic                    sat
);

	logic [ACC_W-1:0]     rem_s [DIV_STEPS+1];
	logic [ACC_W-1:0]     den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] low_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] q_s   [DIV_STEPS+1];
	logic                 neg_s [DIV_STEPS+1];
	logic                 ovf_s [DIV_STEPS+1];

	logic [ACC_W-1:0] a_mag, b_mag;
	logic [Q_WORD-1:0] mag;

	assign a_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
	assign b_mag = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);

	// First stage: magnitudes, sign and the integer overflow check.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[ACC_W-1] ^ den[ACC_W-1];
			ovf_s[0] <= {{FRAC_BITS{1'b0}}, a_mag} >= {b_mag, {FRAC_BITS{1'b0}}};
			den_s[0] <= b_mag;
			rem_s[0] <= a_mag >> FRAC_BITS;
			low_s[0] <= {a_mag[FRAC_BITS-1:0], {(DIV_STEPS-FRAC_BITS){1'b0}}};
			q_s[0]   <= '0;
		end
	end

	// Each stage shifts in one dividend bit and tries one subtraction.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [ACC_W:0]   trial;
		logic [ACC_W+1:0] diff;
		logic             ge;
		assign trial = {rem_s[k-1], low_s[k-1][DIV_STEPS-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_s[k-1]};
		assign ge    = !diff[ACC_W+1];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
				q_s[k]   <= {q_s[k-1][DIV_STEPS-2:0], ge};
				low_s[k] <= low_s[k-1] << 1;
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// Apply the sign and clip to the signed 32-bit range.
	assign mag = q_s[DIV_STEPS];
	always_comb begin
		sat  = 1'b0;
		quot = mag;
		if (ovf_s[DIV_STEPS]) begin
			sat  = 1'b1;
			quot = neg_s[DIV_STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (neg_s[DIV_STEPS]) begin
			if (mag > 32'h8000_0000) begin
				sat  = 1'b1;
				quot = 32'h8000_0000;
			end else begin
				quot = 32'h0 - mag;
			end
		end else if (mag > 32'h7FFF_FFFF) begin
			sat  = 1'b1;
			quot = 32'h7FFF_FFFF;
		end
	end

endmodule

>>> sv/disparity_to_3d_point.sv
// Top level of the disparity-to-3D-point reprojection pipeline.
// Usage:
//   The input channel (in_valid/in_ready) takes one pixel word per in_ready cycle:
//   column, row and a signed disparity with four fraction bits. The output
//   channel (out_valid/out_ready) returns one word per pixel, in order, with
//   point_valid, divide_fault, saturated and the Q16.16 coordinates.
//   The matrix is loaded through cfg_wr_en/cfg_addr/cfg_wdata, two Q16.16
//   coefficients per register, while no pixels are in flight; addresses
//   beyond the eight registers are ignored.
// Timing:
//   Stages, in order: products, row sums, divider setup, 32 divider
//   stages that each produce one quotient bit, and the output register.
//   Throughput is one pixel per cycle while out_ready does not stall the
//   pipeline; X, Y and Z each have their own 32-stage divider lane.
// Reset and stall:
//   Reset clears all valid bits and the matrix registers. When the receiver
//   holds out_ready low with a word waiting, the whole pipeline freezes and
//   in_ready drops; nothing is lost or repeated.
module disparity_to_3d_point import dtp_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [Q_REG_W-1:0]        cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_BITS-1:0]     pixel_col,
	input  logic [COORD_BITS-1:0]     pixel_row,
	input  logic signed [DISP_W-1:0]  disparity_raw,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      point_valid,
	output logic                      divide_fault,
	output logic                      saturated,
	output logic signed [Q_WORD-1:0]  point_x,
	output logic signed [Q_WORD-1:0]  point_y,
	output logic signed [Q_WORD-1:0]  point_z
);

	localparam int PW    = (COORD_BITS + 37 > 48) ? COORD_BITS + 37 : 48;
	localparam int ACC_W = PW + 2;

	logic [Q_REG_W-1:0]      qreg_q [NUM_QREGS];
	logic signed [Q_WORD-1:0] coef [NUM_COEF];
	logic signed [ACC_W-1:0] acc [4];
	ctl_t mac_ctl;
	ctl_t ctl_s [DIV_STEPS+1];
	logic en;
	logic [Q_WORD-1:0] qx, qy, qz;
	logic sx, sy, sz;
	logic out_valid_q;

	// The pipeline advances whenever the output register can move.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QREGS; i++) qreg_q[i] <= '0;
		end else if (cfg_wr_en && (cfg_addr < CFG_ADDR_W'(NUM_QREGS))) begin
			qreg_q[cfg_addr[2:0]] <= cfg_wdata;
		end
	end

	// Row r, column c sits in register 2r + c/2, odd columns in the upper word.
	for (genvar c = 0; c < NUM_COEF; c++) begin : g_coef
		assign coef[c] = $signed(qreg_q[(c/4)*2 + (c%4)/2][((c%4)%2)*Q_WORD +: Q_WORD]);
	end

	dtp_mac #(.COORD_BITS(COORD_BITS), .ACC_W(ACC_W)) u_mac (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.pixel_col(pixel_col), .pixel_row(pixel_row), .disparity_raw(disparity_raw),
		.coef(coef), .acc(acc), .ctl(mac_ctl)
	);

	dtp_div_lane #(.ACC_W(ACC_W)) u_div_x (
		.clk(clk), .en(en), .num(acc[0]), .den(acc[3]), .quot(qx), .sat(sx));
	dtp_div_lane #(.ACC_W(ACC_W)) u_div_y (
		.clk(clk), .en(en), .num(acc[1]), .den(acc[3]), .quot(qy), .sat(sy));
	dtp_div_lane #(.ACC_W(ACC_W)) u_div_z (
		.clk(clk), .en(en), .num(acc[2]), .den(acc[3]), .quot(qz), .sat(sz));

	// Control runs alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) ctl_s[k] <= '0;
		end else if (en) begin
			ctl_s[0].valid <= mac_ctl.valid;
			ctl_s[0].live  <= mac_ctl.live;
			ctl_s[0].fault <= (acc[3] == '0);
			for (int k = 1; k <= DIV_STEPS; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_s[DIV_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s[DIV_STEPS].live && !ctl_s[DIV_STEPS].fault) begin
				point_valid <= 1'b1;
				saturated   <= sx | sy | sz;
				point_x     <= $signed(qx);
				point_y     <= $signed(qy);
				point_z     <= $signed(qz);
			end else begin
				point_valid <= 1'b0;
				saturated   <= 1'b0;
				point_x     <= '0;
				point_y     <= '0;
				point_z     <= '0;
			end
			divide_fault <= ctl_s[DIV_STEPS].live && ctl_s[DIV_STEPS].fault;
		end
	end

	assign out_valid = out_valid_q;

	// A computed point never also reports a divide fault.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(point_valid && divide_fault))
		else $error("point_valid and divide_fault both set");

	// Saturation is only reported on a computed point.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> point_valid)
		else $error("saturated without point_valid");

	// Rejected pixels carry zero coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0)
		else $error("nonzero coordinates on a rejected pixel");

	// A stalled word keeps out_valid high on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> !in_ready || out_valid)
		else $error("output word dropped during stall");

endmodule

>>> tb/sv/disparity_to_3d_point_test.sv
// Self-checking testbench for the disparity-to-3D-point reprojection pipeline.
`timescale 1ns / 100ps

module disparity_to_3d_point_test;
	import dtp_pkg::*;

	localparam int CB = 12;

	// One reprojected point as the block reports it.
	typedef struct packed {
		logic              pv;
		logic              df;
		logic              sat;
		logic [Q_WORD-1:0] x;
		logic [Q_WORD-1:0] y;
		logic [Q_WORD-1:0] z;
	} point_t;

	// One row of the directed stimulus table.
	typedef struct {
		logic [CB-1:0]     col;
		logic [CB-1:0]     row;
		logic [DISP_W-1:0] disp;
		bit                typed;
		point_t            want;
	} pixel_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
	logic [Q_REG_W-1:0]       cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CB-1:0]            pixel_col = '0;
	logic [CB-1:0]            pixel_row = '0;
	logic signed [DISP_W-1:0] disparity_raw = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     point_valid, divide_fault, saturated;
	logic signed [Q_WORD-1:0] point_x, point_y, point_z;

	disparity_to_3d_point #(.COORD_BITS(CB)) dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	logic [Q_REG_W-1:0] matrix_regs [NUM_QREGS];
	point_t             pending_points [$];
	int                 mismatches = 0;
	bit                 allow_stall = 1'b1;

	// Signed coefficient at row r, column c of the held matrix.
	function automatic longint coefficient(int r, int c);
		logic [Q_REG_W-1:0] w;
		w = matrix_regs[r * 2 + c / 2];
		return longint'($signed(w[(c % 2) * 32 +: 32]));
	endfunction

	// Quotient num/den in Q16.16, truncated toward zero and clipped.
	function automatic logic [31:0] scaled_quotient(longint num, longint den, inout bit sat);
		bit         neg;
		logic [63:0] a, b, q, mag;
		logic [79:0] rw;
		neg = (num < 0) != (den < 0);
		a = num < 0 ? -num : num;
		b = den < 0 ? -den : den;
		q = a / b;
		if (q >= 64'h10000) begin
			sat = 1'b1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		rw = 80'(a % b) << 16;
		mag = (q << 16) | 64'(rw / 80'(b));
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'(-mag);
		end
		if (mag > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return mag[31:0];
	endfunction

	// Reprojection of one pixel through the held matrix.
	function automatic point_t reproject(logic [CB-1:0] col, logic [CB-1:0] row,
			logic [DISP_W-1:0] disp);
		point_t p;
		longint v[4], acc[4];
		bit     sat;
		p = '0;
		sat = 1'b0;
		if ($signed(disp) <= 0)
			return p;
		v[0] = longint'(col) * 16;
		v[1] = longint'(row) * 16;
		v[2] = longint'($signed(disp));
		v[3] = 16;
		for (int r = 0; r < 4; r++) begin
			acc[r] = 0;
			for (int c = 0; c < 4; c++)
				acc[r] += coefficient(r, c) * v[c];
		end
		if (acc[3] == 0) begin
			p.df = 1'b1;
			return p;
		end
		p.x = scaled_quotient(acc[0], acc[3], sat);
		p.y = scaled_quotient(acc[1], acc[3], sat);
		p.z = scaled_quotient(acc[2], acc[3], sat);
		p.pv = 1'b1;
		p.sat = sat;
		return p;
	endfunction

	// Register write; indexes past the list are ignored by both sides.
	task automatic write_reg(int idx, logic [Q_REG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx[CFG_ADDR_W-1:0];
		cfg_wdata <= val;
		if (idx < NUM_QREGS)
			matrix_regs[idx] = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait for every expected word, then let the pipeline drain.
	task automatic drain_points();
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_matrix(logic [31:0] m[16]);
		for (int i = 0; i < NUM_QREGS; i++)
			write_reg(i, {m[2 * i + 1], m[2 * i]});
	endtask

	// Send one pixel word, with random source gaps.
	task automatic send_pixel(logic [CB-1:0] col, logic [CB-1:0] row,
			logic [DISP_W-1:0] disp, bit typed, point_t want);
		if (allow_stall && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_col <= col;
		pixel_row <= row;
		disparity_raw <= disp;
		do @(posedge clk); while (!in_ready);
		pending_points.insert(pending_points.size(), typed ? want : reproject(col, row, disp));
	endtask

	// Receiver: random stall bursts and the word check.
	initial begin
		point_t got, want;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{point_valid, divide_fault, saturated, point_x, point_y, point_z};
				if (pending_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %p", got);
				end else begin
					want = pending_points.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (allow_stall && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic logic [31:0] rand_q(int mode);
		case (mode)
			0: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
			1: return $urandom;
			2: return 32'(int'($urandom_range(0, 65536)) - 32768);
			default: return '0;
		endcase
	endfunction

	initial begin
		pixel_row_t  tbl [$];
		logic [31:0] m[16];
		point_t      zero_pt, fault_pt;
		logic [CB-1:0] c, r;
		logic [DISP_W-1:0] d;
		zero_pt = '0;
		fault_pt = '0;
		fault_pt.df = 1'b1;
		foreach (matrix_regs[i])
			matrix_regs[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// After reset the matrix is zero: positive disparity faults, other disparities are rejected.
		tbl.insert(tbl.size(), '{12'd0, 12'd0, 16'sd1, 1'b1, fault_pt});
		tbl.insert(tbl.size(), '{12'hFFF, 12'hFFF, 16'h7FFF, 1'b1, fault_pt});
		tbl.insert(tbl.size(), '{12'd5, 12'd7, 16'h0000, 1'b1, zero_pt});
		tbl.insert(tbl.size(), '{12'd5, 12'd7, 16'h8000, 1'b1, zero_pt});
		tbl.insert(tbl.size(), '{12'd5, 12'd7, 16'hFFFF, 1'b1, zero_pt});
		foreach (tbl[i])
			send_pixel(tbl[i].col, tbl[i].row, tbl[i].disp, tbl[i].typed, tbl[i].want);
		in_valid <= 1'b0;
		drain_points();

		// Typical camera matrix with a write to an ignored address, then extreme coefficients.
		m = '{32'h10000, 0, 0, 32'hFEC0_0000, 0, 32'h10000, 0, 32'hFF10_0000,
			0, 0, 0, 32'h0200_0000, 0, 0, 32'h0000_8000, 0};
		load_matrix(m);
		write_reg(NUM_QREGS + 3, '1);
		tbl.delete();
		tbl.insert(tbl.size(), '{12'd0, 12'd0, 16'sd1, 1'b0, zero_pt});
		tbl.insert(tbl.size(), '{12'hFFF, 12'hFFF, 16'sd1, 1'b0, zero_pt});
		tbl.insert(tbl.size(), '{12'd320, 12'd240, 16'sd16, 1'b0, zero_pt});
		tbl.insert(tbl.size(), '{12'hFFF, 12'd0, 16'h7FFF, 1'b0, zero_pt});
		tbl.insert(tbl.size(), '{12'd0, 12'hFFF, 16'sd2, 1'b0, zero_pt});
		foreach (tbl[i])
			send_pixel(tbl[i].col, tbl[i].row, tbl[i].disp, tbl[i].typed, tbl[i].want);
		in_valid <= 1'b0;
		drain_points();
		for (int i = 0; i < 16; i++)
			m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		load_matrix(m);
		tbl.delete();
		tbl.insert(tbl.size(), '{12'hFFF, 12'hFFF, 16'h7FFF, 1'b0, zero_pt});
		tbl.insert(tbl.size(), '{12'd1, 12'd0, 16'sd1, 1'b0, zero_pt});
		tbl.insert(tbl.size(), '{12'd0, 12'd1, 16'sd3, 1'b0, zero_pt});
		foreach (tbl[i])
			send_pixel(tbl[i].col, tbl[i].row, tbl[i].disp, tbl[i].typed, tbl[i].want);
		in_valid <= 1'b0;
		drain_points();

		// Random matrices and pixels; the last phase runs without stalls.
		for (int ph = 0; ph < 12; ph++) begin
			for (int i = 0; i < 16; i++)
				m[i] = rand_q($urandom_range(0, 3));
			if (ph % 3 == 0)
				m[15] = 32'h0001_0000;
			load_matrix(m);
			if (ph == 11)
				allow_stall = 1'b0;
			for (int k = 0; k < 128; k++) begin
				c = $urandom;
				r = $urandom;
				d = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32767));
				send_pixel(c, r, d, 1'b0, zero_pt);
			end
			in_valid <= 1'b0;
			drain_points();
		end

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
